// ===== hw/rtl/plf_pkg.sv =====
// ---------------------------------------------------------------------------
// plf_pkg
// Shared types and constants of the line-follow steering block.
// ---------------------------------------------------------------------------
`default_nettype none

package plf_pkg;

	// sensor geometry
	localparam int unsigned POS_W      = 12;
	localparam int unsigned POS_CENTER = 2000;
	localparam int unsigned POS_MAX    = 4000;

	// data widths
	localparam int unsigned ERR_W   = 12;  // -2000..2000
	localparam int unsigned DIFF_W  = 13;  // -4000..4000
	localparam int unsigned INT_W   = 32;
	localparam int unsigned QI_W    = 33;  // signed quotient of integral
	localparam int unsigned PROD_W  = 22;  // diff * d_gain
	localparam int unsigned SUM_W   = 34;
	localparam int unsigned SPEED_W = 8;
	localparam int unsigned DIVR_W  = 16;
	localparam int unsigned GAIN_W  = 8;

	// divider
	localparam int unsigned DIV_SHORT_BITS = ERR_W;
	localparam int unsigned DIV_LONG_BITS  = INT_W;
	localparam int unsigned DIV_CNT_W      = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PSTART,
		ST_PWAIT,
		ST_ISTART,
		ST_IWAIT,
		ST_SUM,
		ST_OUT
	} plf_state_t;

	typedef struct packed {
		logic load;       // capture error from the input transaction
		logic upd;        // update difference, last error, integral
		logic div_start;  // start the shared divider
		logic div_long;   // 1: integral division, 0: error division
		logic cap_qp;     // take P quotient, form D product
		logic cap_qi;     // take I quotient
		logic sum_en;     // form steering sum
		logic out_load;   // load result registers
	} plf_cmd_t;

	typedef struct packed {
		logic div_done;
	} plf_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pid_line_follow_steering.sv =====
// ---------------------------------------------------------------------------
// pid_line_follow_steering
// PID steering for a line follower: sensor position in, wheel speeds out.
// ---------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ----------------------------------
//  input     in_valid / in_ready   position[11:0], on_marker
//  output    out_valid / out_ready left_speed[7:0], right_speed[7:0]
//  config    APB psel/penable      paddr[3:2] = register, pwdata[31:0]
//
// An update runs the error division and then the integral division on the
// shared restoring divider (12 steps for the error, 32 for the integral, one
// quotient bit a cycle); the next input transaction is taken in the cycle
// after the result is loaded at the earliest. A marker transaction is taken
// in the idle state and leaves no trace. Reset restores the register
// defaults and clears last error and integral. A waiting result sits in the
// output register; the next input transaction is taken while it waits, and
// only the final load holds until the output side has room.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_line_follow_steering
	import plf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [POS_W-1:0]   position,
	input  wire logic               on_marker,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [SPEED_W-1:0] left_speed,
	output logic      [SPEED_W-1:0] right_speed,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	// register map, word index = paddr[3:2]
	localparam logic [1:0] REG_MAX_SPEED = 2'd0;
	localparam logic [1:0] REG_P_DIV     = 2'd1;
	localparam logic [1:0] REG_I_DIV     = 2'd2;
	localparam logic [1:0] REG_D_GAIN    = 2'd3;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 8'd0;
	localparam logic [DIVR_W-1:0]  P_DIV_RST     = 16'd10;
	localparam logic [DIVR_W-1:0]  I_DIV_RST     = 16'd2000;
	localparam logic [GAIN_W-1:0]  D_GAIN_RST    = 8'd1;

	logic [SPEED_W-1:0] max_speed_q;
	logic [DIVR_W-1:0]  p_divisor_q;
	logic [DIVR_W-1:0]  i_divisor_q;
	logic [GAIN_W-1:0]  d_gain_q;
	logic [1:0]         reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			p_divisor_q <= P_DIV_RST;
			i_divisor_q <= I_DIV_RST;
			d_gain_q    <= D_GAIN_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAX_SPEED: max_speed_q <= pwdata[SPEED_W-1:0];
				REG_P_DIV:     p_divisor_q <= pwdata[DIVR_W-1:0];
				REG_I_DIV:     i_divisor_q <= pwdata[DIVR_W-1:0];
				REG_D_GAIN:    d_gain_q    <= pwdata[GAIN_W-1:0];
				default:       ;
			endcase
		end
	end

	// read-back, zero-extended
	always_comb begin
		unique case (reg_idx)
			REG_MAX_SPEED: prdata = 32'(max_speed_q);
			REG_P_DIV:     prdata = 32'(p_divisor_q);
			REG_I_DIV:     prdata = 32'(i_divisor_q);
			REG_D_GAIN:    prdata = 32'(d_gain_q);
			default:       prdata = '0;
		endcase
	end

	plf_cmd_t cmd;
	plf_sts_t sts;

	// sequencer: one update at a time, result register handshake
	plf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.on_marker(on_marker),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// error, integral, divider, sum and clamp
	plf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.position   (position),
		.max_speed  (max_speed_q),
		.p_divisor  (p_divisor_q),
		.i_divisor  (i_divisor_q),
		.d_gain     (d_gain_q),
		.left_speed (left_speed),
		.right_speed(right_speed)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/plf_div.sv =====
// ---------------------------------------------------------------------------
// plf_div
// Restoring unsigned divider, one quotient bit per cycle, 12 or 32 steps.
// ---------------------------------------------------------------------------
`default_nettype none

module plf_div
	import plf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     long_mode,
	input  wire logic [DIV_LONG_BITS-1:0] dividend,
	input  wire logic [DIVR_W-1:0]        divisor,
	output logic      [DIV_LONG_BITS-1:0] quotient,
	output logic                          done
);

	localparam int unsigned PAD_W = DIV_LONG_BITS - DIV_SHORT_BITS;

	logic                     busy_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic [DIVR_W-1:0]        rem_q;
	logic [DIV_LONG_BITS-1:0] dvd_q;
	logic [DIVR_W:0]          shifted;
	logic [DIVR_W:0]          trial;
	logic                     fits;

	assign shifted = {rem_q, dvd_q[DIV_LONG_BITS-1]};
	assign trial   = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= long_mode ? DIV_CNT_W'(DIV_LONG_BITS) : DIV_CNT_W'(DIV_SHORT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= long_mode ? dividend : {dividend[DIV_SHORT_BITS-1:0], {PAD_W{1'b0}}};
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
			dvd_q <= {dvd_q[DIV_LONG_BITS-2:0], fits};
		end
	end

	assign quotient = dvd_q;
	assign done     = ~busy_q;

endmodule

`default_nettype wire

// ===== hw/rtl/plf_dp.sv =====
// ---------------------------------------------------------------------------
// plf_dp
// Steering datapath: error, integral, shared divider, sum, clamp, speeds.
// ---------------------------------------------------------------------------
`default_nettype none

module plf_dp
	import plf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire plf_cmd_t           cmd,
	output plf_sts_t                sts,
	input  wire logic [POS_W-1:0]   position,
	input  wire logic [SPEED_W-1:0] max_speed,
	input  wire logic [DIVR_W-1:0]  p_divisor,
	input  wire logic [DIVR_W-1:0]  i_divisor,
	input  wire logic [GAIN_W-1:0]  d_gain,
	output logic      [SPEED_W-1:0] left_speed,
	output logic      [SPEED_W-1:0] right_speed
);

	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [INT_W-1:0]  integral_q;
	logic signed [ERR_W-1:0]  qp_q;
	logic signed [QI_W-1:0]   qi_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SPEED_W-1:0]       left_q;
	logic [SPEED_W-1:0]       right_q;
	logic [SPEED_W-1:0]       left_next;
	logic [SPEED_W-1:0]       right_next;

	// input error, position clamped to range
	logic [POS_W-1:0]   pos_c;
	logic [POS_W:0]     err_wide;
	always_comb begin
		pos_c    = (position > POS_W'(POS_MAX)) ? POS_W'(POS_MAX) : position;
		err_wide = {1'b0, pos_c} - (POS_W+1)'(POS_CENTER);
	end

	// saturating integral update
	logic signed [INT_W:0]   int_sum;
	logic signed [INT_W-1:0] int_next;
	always_comb begin
		int_sum = {integral_q[INT_W-1], integral_q} + (INT_W+1)'(err_q);
		if (int_sum[INT_W] != int_sum[INT_W-1]) begin
			int_next = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
		end else begin
			int_next = int_sum[INT_W-1:0];
		end
	end

	// divider operands: magnitudes, zero divisor reads as one
	logic [ERR_W-1:0]         err_mag;
	logic [INT_W-1:0]         int_mag;
	logic [DIV_LONG_BITS-1:0] div_dividend;
	logic [DIVR_W-1:0]        div_divisor;
	logic [DIVR_W-1:0]        p_eff;
	logic [DIVR_W-1:0]        i_eff;
	logic [DIV_LONG_BITS-1:0] quotient;
	logic                     div_done;
	always_comb begin
		err_mag      = err_q[ERR_W-1] ? (~err_q + 1'b1) : err_q;
		int_mag      = integral_q[INT_W-1] ? (~integral_q + 1'b1) : integral_q;
		p_eff        = (p_divisor == '0) ? DIVR_W'(1) : p_divisor;
		i_eff        = (i_divisor == '0) ? DIVR_W'(1) : i_divisor;
		div_dividend = cmd.div_long ? int_mag : DIV_LONG_BITS'(err_mag);
		div_divisor  = cmd.div_long ? i_eff : p_eff;
	end

	plf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.long_mode(cmd.div_long),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	assign sts.div_done = div_done;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			integral_q   <= '0;
		end else if (cmd.upd) begin
			last_error_q <= err_q;
			integral_q   <= int_next;
		end
	end

	// signed quotients, truncation toward zero
	logic [ERR_W-1:0] qp_mag;
	logic [QI_W-1:0]  qi_mag;
	always_comb begin
		qp_mag = quotient[ERR_W-1:0];
		qi_mag = {1'b0, quotient};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= err_wide[ERR_W-1:0];
		end
		if (cmd.upd) begin
			diff_q <= DIFF_W'(err_q) - DIFF_W'(last_error_q);
		end
		if (cmd.cap_qp) begin
			qp_q   <= err_q[ERR_W-1] ? $signed(~qp_mag + 1'b1) : $signed(qp_mag);
			prod_q <= PROD_W'(diff_q) * PROD_W'($signed({1'b0, d_gain}));
		end
		if (cmd.cap_qi) begin
			qi_q <= integral_q[INT_W-1] ? $signed(~qi_mag + 1'b1) : $signed(qi_mag);
		end
		if (cmd.sum_en) begin
			sum_q <= SUM_W'(qp_q) + SUM_W'(qi_q) + SUM_W'(prod_q);
		end
		if (cmd.out_load) begin
			left_q  <= left_next;
			right_q <= right_next;
		end
	end

	// clamp to +/- max_speed, slow the wheel the term points to
	logic signed [SUM_W-1:0] lim;
	logic signed [SUM_W-1:0] neg_sum;
	logic [SPEED_W-1:0]      mag;
	always_comb begin
		lim     = $signed(SUM_W'(max_speed));
		neg_sum = -sum_q;
		if (sum_q[SUM_W-1]) begin
			mag        = (neg_sum > lim) ? max_speed : neg_sum[SPEED_W-1:0];
			left_next  = max_speed - mag;
			right_next = max_speed;
		end else begin
			mag        = (sum_q > lim) ? max_speed : sum_q[SPEED_W-1:0];
			left_next  = max_speed;
			right_next = max_speed - mag;
		end
	end

	assign left_speed  = left_q;
	assign right_speed = right_q;

endmodule

`default_nettype wire

// ===== hw/rtl/plf_ctrl.sv =====
// ---------------------------------------------------------------------------
// plf_ctrl
// Sequencer for one steering update and the result handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module plf_ctrl
	import plf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     on_marker,
	output logic          out_valid,
	input  wire logic     out_ready,
	output plf_cmd_t      cmd,
	input  wire plf_sts_t sts
);

	plf_state_t state_q;
	plf_state_t state_next;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = ~out_valid_q | out_ready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !on_marker) begin
					state_next = ST_PSTART;
				end
			end
			ST_PSTART: state_next = ST_PWAIT;
			ST_PWAIT: begin
				if (sts.div_done) begin
					state_next = ST_ISTART;
				end
			end
			ST_ISTART: state_next = ST_IWAIT;
			ST_IWAIT: begin
				if (sts.div_done) begin
					state_next = ST_SUM;
				end
			end
			ST_SUM: state_next = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid & ~on_marker;
			end
			ST_PSTART: begin
				cmd.upd       = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_PWAIT: cmd.cap_qp = sts.div_done;
			ST_ISTART: begin
				cmd.div_start = 1'b1;
				cmd.div_long  = 1'b1;
			end
			ST_IWAIT: begin
				cmd.div_long = 1'b1;
				cmd.cap_qi   = sts.div_done;
			end
			ST_SUM: cmd.sum_en = 1'b1;
			ST_OUT: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Checks the PID line-follow steering block against its own predictor.
// Transactions go in through a valid/ready sender task. A separate process
// drives the output ready and compares each result with the oldest pending
// pair of predicted wheel speeds. Gains and limits are set over APB only
// while the block is idle. Test phases: register defaults, register
// access, directed extremes, zero divisors, random sweeps, a stretch with
// no idling, output back-pressure, and a drain pause.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import plf_pkg::*;

	// APB register map, one word per register
	typedef enum int unsigned {
		REG_MAX_SPEED,
		REG_P_DIVISOR,
		REG_I_DIVISOR,
		REG_D_GAIN
	} reg_idx_t;

	typedef struct packed {
		logic [SPEED_W-1:0] left;
		logic [SPEED_W-1:0] right;
	} wheel_speeds_t;

	// Settle for a little longer than one update takes.
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned HOLD_CYCLES   = 600;   // long output stall
	localparam int unsigned STALL_LIMIT   = 5000;  // watchdog, cycles with no transaction
	localparam longint      SUM_HI        = 64'sd2147483647;
	localparam longint      SUM_LO        = -64'sd2147483648;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [POS_W-1:0]   position  = '0;
	logic               on_marker = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [SPEED_W-1:0] left_speed;
	logic [SPEED_W-1:0] right_speed;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [3:0]         paddr     = '0;
	logic [31:0]        pwdata    = '0;
	logic [31:0]        prdata;
	logic               pready;

	// Predictor copy of the configuration and the controller state
	logic        [SPEED_W-1:0] cfg_max  = 8'd0;
	logic        [DIVR_W-1:0]  cfg_p    = 16'd10;
	logic        [DIVR_W-1:0]  cfg_i    = 16'd2000;
	logic        [GAIN_W-1:0]  cfg_d    = 8'd1;
	logic signed [ERR_W-1:0]   prev_err = '0;
	logic signed [INT_W-1:0]   err_sum  = '0;

	wheel_speeds_t speed_queue[$];   // predicted speeds, oldest first

	int          errors      = 0;
	int unsigned quiet_cycles = 0;
	bit          tx_idle_on  = 1'b1;
	bit          rx_idle_on  = 1'b1;
	int unsigned hold_req    = 0;    // bumped by a test to request a long stall
	int unsigned hold_seen   = 0;
	int unsigned hold_left   = 0;
	int          walk_pos    = 2000; // slowly drifting line position

	always #5ns clk = ~clk;

	pid_line_follow_steering uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.position    (position),
		.on_marker   (on_marker),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// -----------------------------------------------------------------------
	// Steering predictor. Updates the error history and returns 1 with the
	// wheel speeds when the sample produces a result; a marker sample
	// returns 0 and leaves the state alone.
	// -----------------------------------------------------------------------
	function automatic bit predict_speeds(input logic [POS_W-1:0] pos, input logic mk,
			output wheel_speeds_t res);
		longint e, d, acc, trm, lim, pd, id;
		res = '0;
		if (mk)
			return 1'b0;
		// positions past the sensor range read as the far edge
		e = (pos > POS_MAX) ? longint'(POS_MAX) : longint'(pos);
		e = e - longint'(POS_CENTER);
		d = e - longint'(prev_err);
		// integral saturates at the signed 32-bit bounds
		acc = longint'(err_sum) + e;
		if (acc > SUM_HI)
			acc = SUM_HI;
		if (acc < SUM_LO)
			acc = SUM_LO;
		err_sum  = INT_W'(acc);
		prev_err = ERR_W'(e);
		// a zero divisor acts as one; SV division truncates toward zero
		pd  = (cfg_p == '0) ? 64'sd1 : longint'(cfg_p);
		id  = (cfg_i == '0) ? 64'sd1 : longint'(cfg_i);
		trm = e / pd + longint'(err_sum) / id + d * longint'(cfg_d);
		lim = longint'(cfg_max);
		if (trm > lim)
			trm = lim;
		if (trm < -lim)
			trm = -lim;
		// negative term slows the left wheel, otherwise the right one
		if (trm < 0) begin
			res.left  = SPEED_W'(lim + trm);
			res.right = cfg_max;
		end else begin
			res.left  = cfg_max;
			res.right = SPEED_W'(lim - trm);
		end
		return 1'b1;
	endfunction

	// -----------------------------------------------------------------------
	// APB access. Setup cycle, then access cycle; pready is always high, so
	// the write lands at the edge that ends the access cycle.
	// -----------------------------------------------------------------------
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MAX_SPEED: cfg_max = data[SPEED_W-1:0];
			REG_P_DIVISOR: cfg_p   = data[DIVR_W-1:0];
			REG_I_DIVISOR: cfg_i   = data[DIVR_W-1:0];
			REG_D_GAIN:    cfg_d   = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	// Read back one register. Only the bits the register holds are compared.
	task automatic apb_read_check(input reg_idx_t idx);
		logic [31:0] want;
		logic [31:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 4'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;            // sampled at the edge that ends the access
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MAX_SPEED: begin
				want = 32'(cfg_max);
				got  = got & 32'h0000_00ff;
			end
			REG_P_DIVISOR: begin
				want = 32'(cfg_p);
				got  = got & 32'h0000_ffff;
			end
			REG_I_DIVISOR: begin
				want = 32'(cfg_i);
				got  = got & 32'h0000_ffff;
			end
			default: begin
				want = 32'(cfg_d);
				got  = got & 32'h0000_00ff;
			end
		endcase
		if (got !== want) begin
			errors++;
			$display("%0t: register %s readback mismatch: expected %0d, actual %0d",
				$time, idx.name(), want, got);
		end
	endtask

	// -----------------------------------------------------------------------
	// Sender. Entered and left on a rising edge; leaves valid high after the
	// accepting edge so back-to-back transactions never lower and raise it
	// in the same step.
	// -----------------------------------------------------------------------
	task automatic send_item(input logic [POS_W-1:0] pos, input logic mk);
		wheel_speeds_t res;
		if (tx_idle_on && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		position  <= pos;
		on_marker <= mk;
		do @(posedge clk); while (!in_ready);
		if (predict_speeds(pos, mk, res))
			speed_queue.push_back(res);
	endtask

	// Mostly a drifting line, with jumps, sensor-edge readings, out-of-range
	// readings and markers mixed in.
	task automatic send_random_item();
		int unsigned      pick;
		logic [POS_W-1:0] pos;
		pick = $urandom_range(99);
		if (pick < 50) begin
			walk_pos = walk_pos + int'($urandom_range(200)) - 100;
			if (walk_pos < 0)
				walk_pos = 0;
			if (walk_pos > int'(POS_MAX))
				walk_pos = POS_MAX;
			pos = POS_W'(walk_pos);
		end else if (pick < 58) begin
			pos = POS_W'($urandom_range(4095, POS_MAX + 1));
		end else if (pick < 66) begin
			pos = ($urandom_range(1) == 1) ? POS_W'(POS_MAX) : '0;
		end else begin
			pos = POS_W'($urandom_range(POS_MAX));
		end
		send_item(pos, pick >= 90);
	endtask

	// Drop valid, wait for every predicted result, then let the block settle
	// in case a marker transaction is still being consumed.
	task automatic wait_all_done();
		in_valid <= 1'b0;
		while (speed_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [SPEED_W-1:0] mx, input logic [DIVR_W-1:0] pdv,
			input logic [DIVR_W-1:0] idv, input logic [GAIN_W-1:0] dg);
		wait_all_done();
		apb_write(REG_MAX_SPEED, 32'(mx));
		apb_write(REG_P_DIVISOR, 32'(pdv));
		apb_write(REG_I_DIVISOR, 32'(idv));
		apb_write(REG_D_GAIN, 32'(dg));
	endtask

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Reset values, and a zero max speed pins both wheels at zero.
	task automatic test_reset_defaults();
		apb_read_check(REG_MAX_SPEED);
		apb_read_check(REG_P_DIVISOR);
		apb_read_check(REG_I_DIVISOR);
		apb_read_check(REG_D_GAIN);
		send_item('0, 1'b0);
		send_item(POS_W'(POS_MAX), 1'b0);
	endtask

	// Writes carry junk in the unused upper bits; readback must be masked.
	task automatic test_register_access();
		wait_all_done();
		for (int k = 0; k < 2; k++) begin
			apb_write(REG_MAX_SPEED, (k == 0) ? $urandom() : 32'hffff_ffff);
			apb_write(REG_P_DIVISOR, (k == 0) ? $urandom() : 32'hffff_ffff);
			apb_write(REG_I_DIVISOR, (k == 0) ? $urandom() : 32'hffff_ffff);
			apb_write(REG_D_GAIN, (k == 0) ? $urandom() : 32'hffff_ffff);
			apb_read_check(REG_MAX_SPEED);
			apb_read_check(REG_P_DIVISOR);
			apb_read_check(REG_I_DIVISOR);
			apb_read_check(REG_D_GAIN);
		end
	endtask

	// Full-swing errors, out-of-range positions and markers.
	task automatic test_directed_extremes();
		set_config(8'd255, 16'd1, 16'd65535, 8'd255);
		send_item('0, 1'b0);                    // hard left, max difference
		send_item(POS_W'(POS_MAX), 1'b0);       // hard right, max difference
		send_item('0, 1'b0);
		send_item(POS_W'(POS_CENTER), 1'b0);
		send_item(12'hfff, 1'b0);               // above range, reads as 4000
		send_item(POS_W'(POS_MAX + 1), 1'b0);
		send_item(POS_W'(POS_CENTER), 1'b0);
		set_config(8'd100, 16'd10, 16'd2000, 8'd1);
		send_item(POS_W'(POS_CENTER - 1), 1'b0);
		send_item(POS_W'(POS_CENTER + 1), 1'b0);
		send_item(12'd3000, 1'b0);
		send_item(12'd1000, 1'b1);              // marker: no result, no update
		send_item(12'hfff, 1'b1);
		send_item(12'd1000, 1'b0);
	endtask

	// Zero in either divisor must behave as a divisor of one.
	task automatic test_zero_divisor();
		set_config(8'd200, 16'd0, 16'd0, 8'd0);
		send_item(12'd2100, 1'b0);
		send_item(12'd1900, 1'b0);
		send_item(POS_W'(POS_CENTER), 1'b0);
		send_item(12'hfff, 1'b0);
	endtask

	// Random traffic over a range of gain settings, extremes first.
	task automatic test_random_sweep();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(8'd255, 16'd1, 16'd65535, 8'd0);
				1: set_config(8'd0, 16'd65535, 16'd1, 8'd255);
				2: set_config(8'd128, 16'd10, 16'd2000, 8'd1);
				3: set_config(8'd255, 16'd65535, 16'd65535, 8'd0);
				default: set_config(SPEED_W'($urandom_range(255, 1)),
					DIVR_W'($urandom_range(400, 1)), DIVR_W'($urandom_range(65535, 1)),
					GAIN_W'($urandom_range(4)));
			endcase
			repeat (80) send_random_item();
		end
	endtask

	// Both sides always ready: back-to-back transactions.
	task automatic test_no_idle_stretch();
		set_config(8'd180, 16'd20, 16'd5000, 8'd2);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (100) send_random_item();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Receiver stalls for a long stretch while the sender keeps offering;
	// the result register fills, the next result waits in the sequencer and in_ready stays low.
	task automatic test_backpressure();
		set_config(8'd220, 16'd8, 16'd3000, 8'd1);
		tx_idle_on = 1'b0;
		hold_req++;
		repeat (20) send_random_item();
		tx_idle_on = 1'b1;
	endtask

	// Sender stops until everything is out, then resumes with the same state.
	task automatic test_drain_pause();
		repeat (20) send_random_item();
		in_valid <= 1'b0;
		while (speed_queue.size() != 0)
			@(posedge clk);
		@(posedge clk);
		repeat (20) send_random_item();
	endtask

	// -----------------------------------------------------------------------
	// Receiver: random ready, plus a long hold-off counted here when a test
	// asks for one.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= rx_idle_on ? ($urandom_range(99) >= 33) : 1'b1;
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin : check_results
		wheel_speeds_t want;
		if (arst_n && out_valid && out_ready) begin
			if (speed_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual left %0d right %0d",
					$time, left_speed, right_speed);
			end else begin
				want = speed_queue.pop_front();
				if (left_speed !== want.left) begin
					errors++;
					$display("%0t: left_speed mismatch: expected %0d, actual %0d",
						$time, want.left, left_speed);
				end
				if (right_speed !== want.right) begin
					errors++;
					$display("%0t: right_speed mismatch: expected %0d, actual %0d",
						$time, want.right, right_speed);
				end
			end
		end
	end

	// Watchdog: too long without any transaction on any port ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_access();
		test_directed_extremes();
		test_zero_divisor();
		test_random_sweep();
		test_no_idle_stretch();
		test_backpressure();
		test_drain_pause();

		wait_all_done();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
